// ----- sv/trbs_pkg.sv -----
// shared types and constants for the tied rank binary search block
`timescale 1ns / 1ps

package trbs_pkg;

    localparam int MAX_ENTRIES = 262144;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int SCORE_W     = 32;
    localparam int RANK_W      = 19;

    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ENTRIES);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MID,
        S_LO,
        S_HI,
        S_FIN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_MID,
        RD_LO,
        RD_HI
    } t_rd_sel;

    typedef enum logic [1:0] {
        LO_HOLD,
        LO_MID,
        LO_INC
    } t_lo_op;

    typedef enum logic [1:0] {
        HI_HOLD,
        HI_MID,
        HI_DEC
    } t_hi_op;

    typedef enum logic [1:0] {
        RES_TIED,
        RES_HI,
        RES_LO
    } t_res_op;

    typedef struct packed {
        logic    in_ready;
        logic    wr_en;
        logic    init;
        logic    rd_en;
        t_rd_sel rd_sel;
        t_lo_op  lo_op;
        t_hi_op  hi_op;
        logic    res_load;
        t_res_op res_op;
        logic    out_load;
    } t_ctrl;

    typedef struct packed {
        logic span_one;
        logic eq;
        logic gt;
        logic lt;
        logic out_busy;
    } t_stat;

endpackage

// ----- sv/trbs_ctrl.sv -----
// search controller state machine
`timescale 1ns / 1ps

module trbs_ctrl
    import trbs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_cmd,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_cmd == CMD_QUERY) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_stat.span_one ? S_FIN : S_MID;
            end
            S_MID: begin
                n_state = i_stat.eq ? S_LO : S_CHECK;
            end
            S_LO: begin
                n_state = i_stat.eq ? S_HI : S_CHECK;
            end
            S_HI: begin
                n_state = i_stat.eq ? S_DONE : S_CHECK;
            end
            S_FIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl = '{
            in_ready: 1'b0, wr_en: 1'b0, init: 1'b0, rd_en: 1'b0, rd_sel: RD_MID,
            lo_op: LO_HOLD, hi_op: HI_HOLD, res_load: 1'b0, res_op: RES_LO,
            out_load: 1'b0
        };
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.wr_en    = i_valid && i_cmd == CMD_WRITE;
                o_ctrl.init     = i_valid && i_cmd == CMD_QUERY;
            end
            S_CHECK: begin
                o_ctrl.rd_en  = 1'b1;
                o_ctrl.rd_sel = i_stat.span_one ? RD_HI : RD_MID;
            end
            S_MID: begin
                priority if (i_stat.eq) begin
                    o_ctrl.rd_en  = 1'b1;
                    o_ctrl.rd_sel = RD_LO;
                end else if (i_stat.gt) begin
                    o_ctrl.lo_op = LO_MID;
                end else begin
                    o_ctrl.hi_op = HI_MID;
                end
            end
            S_LO: begin
                if (i_stat.eq) begin
                    o_ctrl.rd_en  = 1'b1;
                    o_ctrl.rd_sel = RD_HI;
                end else begin
                    o_ctrl.lo_op = LO_INC;
                end
            end
            S_HI: begin
                if (i_stat.eq) begin
                    o_ctrl.res_load = 1'b1;
                    o_ctrl.res_op   = RES_TIED;
                end else begin
                    o_ctrl.hi_op = HI_DEC;
                end
            end
            S_FIN: begin
                o_ctrl.res_load = 1'b1;
                o_ctrl.res_op   = i_stat.lt ? RES_HI : RES_LO;
            end
            S_DONE: begin
                o_ctrl.out_load = !i_stat.out_busy;
            end
            default: begin
                o_ctrl.in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/trbs_datapath.sv -----
// score table memory, search bounds, result and output register
`timescale 1ns / 1ps

module trbs_datapath
    import trbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LEN_W-1:0]   i_cfg_wdata,
    input  logic [ADDR_W-1:0]  i_entry_index,
    input  logic [SCORE_W-1:0] i_score,
    input  logic               i_ready,
    input  t_ctrl              i_ctrl,
    output t_stat              o_stat,
    output logic               o_valid,
    output logic [RANK_W-1:0]  o_rank_doubled
);

    logic [SCORE_W-1:0] r_mem [MAX_ENTRIES];

    logic [LEN_W-1:0]   r_table_length;
    logic [ADDR_W-1:0]  r_lo;
    logic [ADDR_W-1:0]  r_hi;
    logic [SCORE_W-1:0] r_query;
    logic [SCORE_W-1:0] r_rdata;
    logic [RANK_W-1:0]  r_result;
    logic               r_out_valid;
    logic [RANK_W-1:0]  r_out_rank;

    logic [LEN_W-1:0]   eff_len;
    logic [ADDR_W-1:0]  span;
    logic [ADDR_W-1:0]  mid;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  mem_addr;

    // clamp the length into the searchable range
    always_comb begin
        priority if (r_table_length < LEN_MIN) begin
            eff_len = LEN_MIN;
        end else if (r_table_length > LEN_MAX) begin
            eff_len = LEN_MAX;
        end else begin
            eff_len = r_table_length;
        end
    end

    assign span = r_hi - r_lo;
    assign mid  = r_lo + (span >> 1);

    always_comb begin
        unique case (i_ctrl.rd_sel)
            RD_MID:  rd_addr = mid;
            RD_LO:   rd_addr = r_lo;
            RD_HI:   rd_addr = r_hi;
            default: rd_addr = mid;
        endcase
    end

    assign mem_addr = i_ctrl.wr_en ? i_entry_index : rd_addr;

    // single port: writes only happen while idle, reads only while searching
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[mem_addr] <= i_score;
        end else if (i_ctrl.rd_en) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= LEN_MIN;
        end else if (i_cfg_we) begin
            r_table_length <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.init) begin
            r_query <= i_score;
            r_lo    <= '0;
            r_hi    <= ADDR_W'(eff_len - LEN_W'(1));
        end else begin
            unique case (i_ctrl.lo_op)
                LO_MID:  r_lo <= mid;
                LO_INC:  r_lo <= r_lo + ADDR_W'(1);
                default: r_lo <= r_lo;
            endcase
            unique case (i_ctrl.hi_op)
                HI_MID:  r_hi <= mid;
                HI_DEC:  r_hi <= r_hi - ADDR_W'(1);
                default: r_hi <= r_hi;
            endcase
        end
    end

    // rank is kept doubled so a tied midpoint stays exact
    always_ff @(posedge i_clk) begin
        if (i_ctrl.res_load) begin
            unique case (i_ctrl.res_op)
                RES_TIED: r_result <= RANK_W'({1'b0, r_lo} + {1'b0, r_hi});
                RES_HI:   r_result <= RANK_W'({r_hi, 1'b0});
                default:  r_result <= RANK_W'({r_lo, 1'b0});
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_out_rank <= r_result;
        end
    end

    assign o_stat.span_one = (span == ADDR_W'(1));
    assign o_stat.eq       = (r_rdata == r_query);
    assign o_stat.gt       = (r_rdata > r_query);
    assign o_stat.lt       = (r_rdata < r_query);
    assign o_stat.out_busy = r_out_valid && !i_ready;

    assign o_valid        = r_out_valid;
    assign o_rank_doubled = r_out_rank;

endmodule

// ----- sv/tied_rank_binary_search.sv -----
// top level: rank of a score in a descending table, ties resolved to the midpoint
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  input    | i_valid / o_ready    | i_cmd, i_entry_index, i_score
//  result   | o_valid / i_ready    | o_rank_doubled
//  config   | i_cfg_we             | i_cfg_wdata (table length)
//
// a table write is stored in the cycle it is accepted; a query with k halving steps (about
// log2 of the length) runs the accept, a check and a compare per step, then the final read,
// the result load and the output load. a run of equal scores is narrowed by stepping the
// low end up, then the high end down, until both ends hold the query.
// every step waits on one registered read of the single memory port.
// one query is searched at a time; its rank sits in an output register so the next word
// is taken while that result waits on i_ready, but a finished query stalls until the
// previous rank has been taken.
// synchronous active low reset clears the controller, the output valid and sets
// the table length to 2; table contents are not cleared and read as garbage
// until written.
`timescale 1ns / 1ps

module tied_rank_binary_search
    import trbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LEN_W-1:0]   i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_cmd,
    input  logic [ADDR_W-1:0]  i_entry_index,
    input  logic [SCORE_W-1:0] i_score,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [RANK_W-1:0]  o_rank_doubled
);

    t_ctrl ctrl;
    t_stat stat;

    trbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    trbs_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_entry_index  (i_entry_index),
        .i_score        (i_score),
        .i_ready        (i_ready),
        .i_ctrl         (ctrl),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_rank_doubled (o_rank_doubled)
    );

    assign o_ready = ctrl.in_ready;

    // memory port is never asked to read and write in the same cycle
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctrl.wr_en && ctrl.rd_en))
        else $error("score memory read and write collide");

    // a query blocks further words while it searches
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_cmd == CMD_QUERY) |=> !o_ready)
        else $error("input taken during a search");

    // a finished rank lands in the output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.out_load |=> o_valid)
        else $error("result lost on load");

    // a table write never produces a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_cmd == CMD_WRITE && !o_valid) |=> !o_valid)
        else $error("result after a table write");

endmodule
